[hw/rtl/rttc_pkg.sv]
`timescale 1ns / 1ps

package rttc_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int IDX_W   = 8;
  localparam int RSQ_W   = 32;
  localparam int MAG_W   = 32;
  localparam int FRAC_W  = 4;
  localparam int HW_W    = 16;
  localparam int LIM_W   = 16;
  localparam int THR_W   = 8;
  localparam int DOT_W   = 33;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TTC_THR    = 2'd3;

  localparam logic [FRAC_W-1:0] RST_FRAC_BITS  = 4'd7;
  localparam logic [HW_W-1:0]   RST_HALF_WIDTH = 16'd384;
  localparam logic [LIM_W-1:0]  RST_RANGE_LIM  = 16'd1280;
  localparam logic [RSQ_W-1:0]  RST_RANGE_SQ   = 32'd1638400;  // 1280 squared
  localparam logic [THR_W-1:0]  RST_TTC_THR    = 8'd32;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic [HW_W-1:0]   half_width;
    logic [RSQ_W-1:0]  lim_sq;
    logic [THR_W-1:0]  thr;
  } cfg_t;

  // Raw object as taken from the input channel
  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] vel_x;
    logic [COORD_W-1:0] vel_y;
    logic               last_object;
    logic               empty_frame;
  } obj_t;

  // Object after the product stage
  typedef struct packed {
    logic [RSQ_W-1:0] range_sq;
    logic             appr;
    logic [MAG_W-1:0] mag;
    logic             in_x;
    logic             last_object;
    logic             empty_frame;
  } prod_t;

  // Frame summary handed to the decision stage
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [RSQ_W-1:0] range_sq;
    logic             appr;
    logic [MAG_W-1:0] mag;
  } snap_t;

endpackage

[hw/rtl/rttc_if.sv]
`timescale 1ns / 1ps

interface rttc_in_if;
  import rttc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] vel_x;
  logic signed [COORD_W-1:0] vel_y;
  logic                      last_object;
  logic                      empty_frame;

  modport source (
    output valid, pos_x, pos_y, vel_x, vel_y, last_object, empty_frame,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, vel_x, vel_y, last_object, empty_frame,
    output ready
  );
endinterface

interface rttc_out_if;
  import rttc_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] nearest_index;
  logic [RSQ_W-1:0] nearest_range_sq;
  logic             approaching;
  logic             brake;

  modport source (
    output valid, found, nearest_index, nearest_range_sq, approaching, brake,
    input  ready
  );
  modport sink (
    input  valid, found, nearest_index, nearest_range_sq, approaching, brake,
    output ready
  );
endinterface

[hw/rtl/rttc_prod.sv]
`timescale 1ns / 1ps

// Input register, then squared range, radial product and lateral test.
module rttc_prod #(
  parameter int COORD_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rttc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  rttc_pkg::obj_t  in_obj,
  output logic            prod_valid,
  input  logic            prod_ready,
  output rttc_pkg::prod_t prod
);
  import rttc_pkg::*;

  localparam int SH = COORD_W - COORD_BITS;

  function automatic logic signed [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] t;
    t = v << SH;
    return $signed(t) >>> SH;
  endfunction

  logic  s1_v_r, s1_v_nxt;
  obj_t  s1_r;
  logic  s2_v_r, s2_v_nxt;
  prod_t s2_r, s2_nxt;
  logic  s1_free, s2_free;

  logic signed [COORD_W-1:0] x, y, vx, vy;
  logic signed [2*COORD_W-1:0] xx, yy, xvx, yvy;
  logic signed [DOT_W-1:0] dot;
  logic [COORD_W-1:0] ax;
  logic [31:0] x_lhs, x_rhs;

  assign s2_free  = !s2_v_r || prod_ready;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign s1_v_nxt = s1_free ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_free ? s1_v_r : s2_v_r;

  always_comb begin
    x   = sext(s1_r.pos_x);
    y   = sext(s1_r.pos_y);
    vx  = sext(s1_r.vel_x);
    vy  = sext(s1_r.vel_y);
    xx  = x * x;
    yy  = y * y;
    xvx = x * vx;
    yvy = y * vy;
    dot = DOT_W'(xvx) + DOT_W'(yvy);
    // magnitude of the most negative value still fits as unsigned
    ax  = x[COORD_W-1] ? COORD_W'(-x) : x;
    // |x| * 2^8 <= half_width * 2^F
    x_lhs = {8'd0, ax, 8'd0};
    x_rhs = 32'(cfg.half_width) << cfg.frac;

    s2_nxt.range_sq    = RSQ_W'(xx) + RSQ_W'(yy);
    s2_nxt.appr        = dot[DOT_W-1];
    s2_nxt.mag         = dot[DOT_W-1] ? MAG_W'(-dot) : dot[MAG_W-1:0];
    s2_nxt.in_x        = (x_lhs <= x_rhs);
    s2_nxt.last_object = s1_r.last_object;
    s2_nxt.empty_frame = s1_r.empty_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_r <= in_obj;
    end
    if (s2_free && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign prod_valid = s2_v_r;
  assign prod       = s2_r;

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !prod_ready |=> s2_v_r && $stable(s2_r))
    else $error("product stage dropped or changed a stalled object");
endmodule

[hw/rtl/rttc_track.sv]
`timescale 1ns / 1ps

// Region test on range, running nearest-candidate search, frame summary register.
module rttc_track #(
  parameter int MAX_OBJECTS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rttc_pkg::cfg_t  cfg,
  input  logic            prod_valid,
  output logic            prod_ready,
  input  rttc_pkg::prod_t prod,
  output logic            snap_valid,
  input  logic            snap_ready,
  output rttc_pkg::snap_t snap
);
  import rttc_pkg::*;

  localparam int CAP_RAW = MAX_OBJECTS - 1;
  localparam int CAP     = (CAP_RAW > 255) ? 255 : CAP_RAW;
  localparam logic [IDX_W-1:0] COUNT_CAP = IDX_W'(CAP);

  logic [RSQ_W-1:0] best_rs_r, best_rs_nxt;
  logic             best_appr_r, best_appr_nxt;
  logic [MAG_W-1:0] best_mag_r, best_mag_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             have_r, have_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic             snap_v_r, snap_v_nxt;
  snap_t            snap_r, snap_nxt;

  logic        close, go, snap_free, in_r, take;
  logic [63:0] r_lhs, r_rhs;

  assign close      = prod.last_object || prod.empty_frame;
  assign snap_free  = !snap_v_r || snap_ready;
  // a non-closing object retires into the running state and needs no summary slot
  assign prod_ready = !close || snap_free;
  assign go         = prod_valid && prod_ready;

  always_comb begin
    // range^2 * 2^16 <= limit^2 * 2^(2F)
    r_lhs = {16'd0, prod.range_sq, 16'd0};
    r_rhs = 64'(cfg.lim_sq) << {cfg.frac, 1'b0};
    in_r  = (r_lhs <= r_rhs);
    take  = !prod.empty_frame && prod.in_x && in_r &&
            (!have_r || (prod.range_sq < best_rs_r));

    best_rs_nxt   = take ? prod.range_sq : best_rs_r;
    best_appr_nxt = take ? prod.appr     : best_appr_r;
    best_mag_nxt  = take ? prod.mag      : best_mag_r;
    best_idx_nxt  = take ? count_r       : best_idx_r;
    have_nxt      = have_r || take;
    count_nxt     = (!prod.empty_frame && (count_r < COUNT_CAP)) ?
                    count_r + 1'b1 : count_r;

    snap_nxt.found    = have_nxt;
    snap_nxt.idx      = have_nxt ? best_idx_nxt  : '0;
    snap_nxt.range_sq = have_nxt ? best_rs_nxt   : '0;
    snap_nxt.appr     = have_nxt ? best_appr_nxt : 1'b0;
    snap_nxt.mag      = have_nxt ? best_mag_nxt  : '0;

    snap_v_nxt = snap_free ? (go && close) : snap_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_rs_r   <= '1;
      best_appr_r <= 1'b0;
      best_mag_r  <= '0;
      best_idx_r  <= '0;
      have_r      <= 1'b0;
      count_r     <= '0;
      snap_v_r    <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (go) begin
        if (close) begin
          best_rs_r   <= '1;
          best_appr_r <= 1'b0;
          best_mag_r  <= '0;
          best_idx_r  <= '0;
          have_r      <= 1'b0;
          count_r     <= '0;
        end else begin
          best_rs_r   <= best_rs_nxt;
          best_appr_r <= best_appr_nxt;
          best_mag_r  <= best_mag_nxt;
          best_idx_r  <= best_idx_nxt;
          have_r      <= have_nxt;
          count_r     <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && close) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && close |=> !have_r && (count_r == '0) && snap_v_r)
    else $error("frame close did not clear the search or post a summary");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_CAP)
    else $error("object count ran past its cap");

  a_idx_seen: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (best_idx_r < count_r) || (count_r == COUNT_CAP))
    else $error("best index ahead of object count");
endmodule

[hw/rtl/rttc_decide.sv]
`timescale 1ns / 1ps

// Time-to-collision test on the frame summary and the result register.
module rttc_decide (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rttc_pkg::cfg_t         cfg,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  input  rttc_pkg::snap_t        snap,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [rttc_pkg::IDX_W-1:0] nearest_index,
  output logic [rttc_pkg::RSQ_W-1:0] nearest_range_sq,
  output logic                   approaching,
  output logic                   brake
);
  import rttc_pkg::*;

  localparam int PW = THR_W + MAG_W;

  logic             out_v_r, out_v_nxt;
  logic             found_r;
  logic [IDX_W-1:0] idx_r;
  logic [RSQ_W-1:0] rs_r;
  logic             appr_r;
  logic             brake_r, brake_nxt;
  logic [PW-1:0]    thr_mag, rs_scaled;

  assign snap_ready = !out_v_r || out_ready;
  assign out_v_nxt  = snap_ready ? snap_valid : out_v_r;

  always_comb begin
    // 16 * range^2 < T * |radial product|
    thr_mag   = PW'(cfg.thr) * PW'(snap.mag);
    rs_scaled = PW'({snap.range_sq, 4'd0});
    brake_nxt = snap.appr && (rs_scaled < thr_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      found_r <= snap.found;
      idx_r   <= snap.idx;
      rs_r    <= snap.range_sq;
      appr_r  <= snap.appr;
      brake_r <= brake_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign found            = found_r;
  assign nearest_index    = idx_r;
  assign nearest_range_sq = rs_r;
  assign approaching      = appr_r;
  assign brake            = brake_r;

  a_brake_needs_appr: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && brake_r |-> appr_r && found_r)
    else $error("brake raised without an approaching candidate");
endmodule

[hw/rtl/radar_nearest_object_ttc_brake_core.sv]
`timescale 1ns / 1ps

// Nearest-object time-to-collision brake decision. Objects of a radar frame
// arrive one per transfer on in_ch; each one inside the region of interest
// (|x| within the lateral limit, range within the range limit and checked on
// squares) competes for nearest, the earliest winning a tie. The item that
// closes the frame (last_object set, or an empty_frame item) yields one result
// transfer on out_ch with the nearest index, its squared range, the approach
// flag and brake, raised when approaching and 16*range^2 < T*|x*vx+y*vy|.
// Throughput is one object per clock unless a closing object waits on a
// stalled result: four register stages (input, products, nearest-search with
// frame summary, brake decision/result) each hold one item; the combinational
// multiplies plus the running-minimum update set that figure. A waiting result
// does not hold up objects that do not close a frame. Configuration is written
// through cfg_we/cfg_idx/cfg_wdata; the user must do so only while no frame is
// in flight, which the block itself does not enforce.
module radar_nearest_object_ttc_brake_core #(
  parameter int MAX_OBJECTS = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rttc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rttc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  rttc_in_if.sink                            in_ch,
  rttc_out_if.source                         out_ch
);
  import rttc_pkg::*;

  // Configuration registers; the squared range limit is kept alongside
  // so the range test needs no multiplier in the object path.
  logic [FRAC_W-1:0] frac_r;
  logic [HW_W-1:0]   hw_r;
  logic [LIM_W-1:0]  lim_r;
  logic [RSQ_W-1:0]  lim_sq_r;
  logic [THR_W-1:0]  thr_r;
  cfg_t              cfg;

  obj_t  in_obj;
  logic  prod_valid, prod_ready;
  prod_t prod;
  logic  snap_valid, snap_ready;
  snap_t snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r   <= RST_FRAC_BITS;
      hw_r     <= RST_HALF_WIDTH;
      lim_r    <= RST_RANGE_LIM;
      lim_sq_r <= RST_RANGE_SQ;
      thr_r    <= RST_TTC_THR;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAC_BITS:  frac_r <= cfg_wdata[FRAC_W-1:0];
        REG_HALF_WIDTH: hw_r   <= cfg_wdata[HW_W-1:0];
        REG_RANGE_LIM: begin
          lim_r    <= cfg_wdata[LIM_W-1:0];
          lim_sq_r <= RSQ_W'(cfg_wdata[LIM_W-1:0]) * RSQ_W'(cfg_wdata[LIM_W-1:0]);
        end
        REG_TTC_THR:    thr_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.frac       = frac_r;
    cfg.half_width = hw_r;
    cfg.lim_sq     = lim_sq_r;
    cfg.thr        = thr_r;

    in_obj.pos_x       = in_ch.pos_x;
    in_obj.pos_y       = in_ch.pos_y;
    in_obj.vel_x       = in_ch.vel_x;
    in_obj.vel_y       = in_ch.vel_y;
    in_obj.last_object = in_ch.last_object;
    in_obj.empty_frame = in_ch.empty_frame;
  end

  // Stage 1-2: input register, products and lateral test
  rttc_prod #(
    .COORD_BITS (COORD_BITS)
  ) u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_obj     (in_obj),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  // Stage 3: range test, nearest search, frame summary
  rttc_track #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Stage 4: brake decision into the result register
  rttc_decide u_decide (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .found            (out_ch.found),
    .nearest_index    (out_ch.nearest_index),
    .nearest_range_sq (out_ch.nearest_range_sq),
    .approaching      (out_ch.approaching),
    .brake            (out_ch.brake)
  );

  a_lim_sq_match: assert property (@(posedge clk) disable iff (!rst_n)
    lim_sq_r == RSQ_W'(lim_r) * RSQ_W'(lim_r))
    else $error("squared range limit out of step with range limit");
endmodule
